### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the temperature statistics core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### rtl/core/tbs_pkg.sv
// ----------------------------------------------------------------------------
// Temperature band statistics package
// Widths, register indexes, band codes and the summary record passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam int LEVEL_W = 15;
    localparam int CNT_W   = 8;
    localparam int SUM_W   = 22;
    localparam int IDX_W   = 7;
    localparam int NUM_BANDS = 4;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]   POS_MAX   = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0]   INDEX_MAX = {IDX_W{1'b1}};

    // Reset values of the threshold registers, in 1/16 degree units.
    localparam logic [LEVEL_W-1:0] WARNING_RESET  = 15'd480;
    localparam logic [LEVEL_W-1:0] CRITICAL_RESET = 15'd720;
    localparam logic [LEVEL_W-1:0] SHUTDOWN_RESET = 15'd960;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_WARNING  = 2'd0;
    localparam cfg_index_t REG_CRITICAL = 2'd1;
    localparam cfg_index_t REG_SHUTDOWN = 2'd2;

    typedef enum logic [1:0] {
        BAND_NORMAL,
        BAND_WARNING,
        BAND_CRITICAL,
        BAND_SHUTDOWN
    } band_t;

    // Summary queue geometry.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Divider runs one quotient bit per cycle.
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } back_state_t;

    // Totals of one closed set, before the average is worked out.
    typedef struct packed {
        logic [LEVEL_W-1:0] min_val;
        logic [LEVEL_W-1:0] max_val;
        logic [SUM_W-1:0]   sum;
        logic [CNT_W-1:0]   valid_cnt;
        logic [CNT_W-1:0]   skip_cnt;
        logic [CNT_W-1:0]   normal_cnt;
        logic [CNT_W-1:0]   warning_cnt;
        logic [CNT_W-1:0]   critical_cnt;
        logic [CNT_W-1:0]   shutdown_cnt;
        logic               crit_flag;
        logic [IDX_W-1:0]   crit_index;
    } summary_t;

endpackage

### rtl/core/tbs_front.sv
// ----------------------------------------------------------------------------
// Temperature statistics front end
// Accepts one reading a cycle unless stalled, puts a non-negative one in a band,
// keeps the open set's running totals; the last reading queues its summary.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbs_front #(
    parameter int MAX_READINGS = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [15:0]         reading,
    input  logic                       last_reading,
    input  logic                       cfg_we,
    input  tbs_pkg::cfg_index_t        cfg_index,
    input  logic [tbs_pkg::LEVEL_W-1:0] cfg_wdata,
    input  logic                       q_full,
    output logic                       push,
    output tbs_pkg::summary_t          push_data
);
    import tbs_pkg::*;

    localparam int CAP_INT = (MAX_READINGS < 255) ? MAX_READINGS : 255;
    localparam logic [CNT_W-1:0] CAP = CAP_INT[CNT_W-1:0];

    logic [LEVEL_W-1:0] warn_level_reg;
    logic [LEVEL_W-1:0] crit_level_reg;
    logic [LEVEL_W-1:0] shut_level_reg;

    logic [LEVEL_W-1:0] min_reg, min_next;
    logic [LEVEL_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   valid_cnt_reg, valid_cnt_next;
    logic [CNT_W-1:0]   skip_cnt_reg, skip_cnt_next;
    logic [CNT_W-1:0]   band_cnt_reg [NUM_BANDS];
    logic [CNT_W-1:0]   band_cnt_next [NUM_BANDS];
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   crit_idx_reg, crit_idx_next;
    logic               crit_flag_reg, crit_flag_next;
    logic               none_valid_reg, none_valid_next;

    logic               accept;
    logic               negative;
    logic [LEVEL_W-1:0] value;
    logic [SUM_W:0]     sum_add;
    band_t              band;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign negative = reading[15];
    assign value    = reading[LEVEL_W-1:0];
    assign sum_add  = {1'b0, sum_reg} + {{(SUM_W+1-LEVEL_W){1'b0}}, value};

    // Threshold registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_level_reg <= WARNING_RESET;
            crit_level_reg <= CRITICAL_RESET;
            shut_level_reg <= SHUTDOWN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WARNING:  warn_level_reg <= cfg_wdata;
                REG_CRITICAL: crit_level_reg <= cfg_wdata;
                REG_SHUTDOWN: shut_level_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Band of the current reading, following the fixed threshold chain.
    always_comb
    begin
        if (value < warn_level_reg)
            band = BAND_NORMAL;
        else if (value < crit_level_reg)
            band = BAND_WARNING;
        else if (value < shut_level_reg)
            band = BAND_CRITICAL;
        else
            band = BAND_SHUTDOWN;
    end

    // Running totals after the current beat.
    always_comb
    begin
        min_next        = min_reg;
        max_next        = max_reg;
        sum_next        = sum_reg;
        valid_cnt_next  = valid_cnt_reg;
        skip_cnt_next   = skip_cnt_reg;
        pos_next        = pos_reg;
        crit_idx_next   = crit_idx_reg;
        crit_flag_next  = crit_flag_reg;
        none_valid_next = none_valid_reg;
        for (int i = 0; i < NUM_BANDS; i++)
            band_cnt_next[i] = band_cnt_reg[i];

        if (accept)
        begin
            if (negative)
            begin
                if (skip_cnt_reg < CAP)
                    skip_cnt_next = skip_cnt_reg + 1'b1;
            end
            else
            begin
                if (none_valid_reg)
                begin
                    min_next        = value;
                    max_next        = value;
                    none_valid_next = 1'b0;
                end
                else
                begin
                    if (value < min_reg)
                        min_next = value;
                    if (value > max_reg)
                        max_next = value;
                end

                // Readings past the count cap no longer enter the sum.
                if (valid_cnt_reg < CAP)
                begin
                    sum_next       = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                    valid_cnt_next = valid_cnt_reg + 1'b1;
                end

                for (int i = 0; i < NUM_BANDS; i++)
                begin
                    if (band == band_t'(i) && band_cnt_reg[i] < CAP)
                        band_cnt_next[i] = band_cnt_reg[i] + 1'b1;
                end

                if (!crit_flag_reg && value >= crit_level_reg)
                begin
                    crit_flag_next = 1'b1;
                    crit_idx_next  = (pos_reg > {1'b0, INDEX_MAX}) ? INDEX_MAX
                                                                   : pos_reg[IDX_W-1:0];
                end
            end

            if (pos_reg < POS_MAX)
                pos_next = pos_reg + 1'b1;
        end
    end

    // The closing reading hands the finished totals to the queue.
    assign push = accept && last_reading;

    always_comb
    begin
        push_data.min_val      = min_next;
        push_data.max_val      = max_next;
        push_data.sum          = sum_next;
        push_data.valid_cnt    = valid_cnt_next;
        push_data.skip_cnt     = skip_cnt_next;
        push_data.normal_cnt   = band_cnt_next[BAND_NORMAL];
        push_data.warning_cnt  = band_cnt_next[BAND_WARNING];
        push_data.critical_cnt = band_cnt_next[BAND_CRITICAL];
        push_data.shutdown_cnt = band_cnt_next[BAND_SHUTDOWN];
        push_data.crit_flag    = crit_flag_next;
        push_data.crit_index   = crit_idx_next;
    end

    // Running state; a closed set starts over from the cleared values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg        <= '0;
            max_reg        <= '0;
            sum_reg        <= '0;
            valid_cnt_reg  <= '0;
            skip_cnt_reg   <= '0;
            pos_reg        <= '0;
            crit_idx_reg   <= '0;
            crit_flag_reg  <= 1'b0;
            none_valid_reg <= 1'b1;
            for (int i = 0; i < NUM_BANDS; i++)
                band_cnt_reg[i] <= '0;
        end
        else if (push)
        begin
            min_reg        <= '0;
            max_reg        <= '0;
            sum_reg        <= '0;
            valid_cnt_reg  <= '0;
            skip_cnt_reg   <= '0;
            pos_reg        <= '0;
            crit_idx_reg   <= '0;
            crit_flag_reg  <= 1'b0;
            none_valid_reg <= 1'b1;
            for (int i = 0; i < NUM_BANDS; i++)
                band_cnt_reg[i] <= '0;
        end
        else
        begin
            min_reg        <= min_next;
            max_reg        <= max_next;
            sum_reg        <= sum_next;
            valid_cnt_reg  <= valid_cnt_next;
            skip_cnt_reg   <= skip_cnt_next;
            pos_reg        <= pos_next;
            crit_idx_reg   <= crit_idx_next;
            crit_flag_reg  <= crit_flag_next;
            none_valid_reg <= none_valid_next;
            for (int i = 0; i < NUM_BANDS; i++)
                band_cnt_reg[i] <= band_cnt_next[i];
        end
    end

    // Only a valid reading can set the critical flag.
    `ASSERT_CLK(a_crit_valid, crit_flag_reg |-> !none_valid_reg, "critical without valid reading")

endmodule

### rtl/core/tbs_queue.sv
// ----------------------------------------------------------------------------
// Temperature statistics summary queue
// Two-entry register queue that decouples the front end from the divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tbs_pkg::summary_t push_data,
    input  logic              pop,
    output tbs_pkg::summary_t pop_data,
    output logic              full,
    output logic              empty
);
    import tbs_pkg::*;

    summary_t           entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Storage needs no reset; the count marks what is live.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `ASSERT_NEVER(a_q_no_overflow, push && full, "summary pushed into a full queue")
    `ASSERT_NEVER(a_q_no_underflow, pop && empty, "summary popped from an empty queue")

endmodule

### rtl/core/tbs_back.sv
// ----------------------------------------------------------------------------
// Temperature statistics back end
// Takes one summary from the queue, divides the sum by the valid count one
// quotient bit per cycle and presents the finished summary on the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    output logic                        pop,
    input  tbs_pkg::summary_t           q_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tbs_pkg::LEVEL_W-1:0] min_valid,
    output logic [tbs_pkg::LEVEL_W-1:0] max_valid,
    output logic [tbs_pkg::LEVEL_W-1:0] average_valid,
    output logic [tbs_pkg::CNT_W-1:0]   valid_total,
    output logic [tbs_pkg::CNT_W-1:0]   skipped_total,
    output logic [tbs_pkg::CNT_W-1:0]   normal_total,
    output logic [tbs_pkg::CNT_W-1:0]   warning_total,
    output logic [tbs_pkg::CNT_W-1:0]   critical_total,
    output logic [tbs_pkg::CNT_W-1:0]   shutdown_total,
    output logic                        critical_seen,
    output logic [tbs_pkg::IDX_W-1:0]   first_critical_index
);
    import tbs_pkg::*;

    back_state_t        state_reg, state_next;
    summary_t           snap_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [STEP_W-1:0]  step_reg;
    summary_t           out_sum_reg;
    logic [LEVEL_W-1:0] out_avg_reg;
    logic               out_valid_reg;

    logic               load_out;
    logic [CNT_W:0]     rem_shift;
    logic [CNT_W:0]     divisor;
    logic [CNT_W:0]     rem_sub;
    logic               rem_ge;
    logic [LEVEL_W-1:0] avg_value;

    // Sequencer: take a summary, divide, then hand over to the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (step_reg == STEP_LAST)
                    state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // One restoring division step: shift in the next dividend bit and subtract.
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign divisor   = {1'b0, snap_reg.valid_cnt};
    assign rem_sub   = rem_shift - divisor;
    assign rem_ge    = (rem_shift >= divisor);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (pop)
            step_reg <= '0;
        else if (state_reg == B_DIV)
            step_reg <= step_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            snap_reg <= q_data;
            quo_reg  <= q_data.sum;
            rem_reg  <= '0;
        end
        else if (state_reg == B_DIV)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        end
    end

    // Average: zero for an empty set, saturated to the level range otherwise.
    always_comb
    begin
        if (snap_reg.valid_cnt == '0)
            avg_value = '0;
        else if (|quo_reg[SUM_W-1:LEVEL_W])
            avg_value = LEVEL_MAX;
        else
            avg_value = quo_reg[LEVEL_W-1:0];
    end

    // Output register; a new result may load in the cycle the old beat leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_sum_reg <= snap_reg;
            out_avg_reg <= avg_value;
        end
    end

    assign out_valid            = out_valid_reg;
    assign min_valid            = out_sum_reg.min_val;
    assign max_valid            = out_sum_reg.max_val;
    assign average_valid        = out_avg_reg;
    assign valid_total          = out_sum_reg.valid_cnt;
    assign skipped_total        = out_sum_reg.skip_cnt;
    assign normal_total         = out_sum_reg.normal_cnt;
    assign warning_total        = out_sum_reg.warning_cnt;
    assign critical_total       = out_sum_reg.critical_cnt;
    assign shutdown_total       = out_sum_reg.shutdown_cnt;
    assign critical_seen        = out_sum_reg.crit_flag;
    assign first_critical_index = out_sum_reg.crit_flag ? out_sum_reg.crit_index : '0;

    // The mean of the counted readings never exceeds the largest valid reading.
    `ASSERT_CLK(a_avg_below_max, out_valid_reg |-> (out_avg_reg <= out_sum_reg.max_val), "average above maximum")
    // A set without valid readings reports all-zero extremes and average.
    `ASSERT_CLK(a_empty_set_zero, (out_valid_reg && (out_sum_reg.valid_cnt == '0)) |-> ((out_avg_reg == '0) && (out_sum_reg.min_val == '0) && (out_sum_reg.max_val == '0)), "nonzero statistics for a set without valid readings")

endmodule

### rtl/core/temperature_band_statistics_core.sv
// ----------------------------------------------------------------------------
// Temperature band statistics core
// Running min, max, average and band counts over sets of temperature readings.
// ----------------------------------------------------------------------------
// The core takes one reading beat per cycle on the input channel while in_stall
// is low and closes a set on the beat marked last_reading; for each set it
// gives one summary beat. Classification and the running totals are done in
// the front end at the full input rate. Each closed set then goes through a
// two-entry summary queue into the back end, which takes the summary, runs its
// bit-serial divider to form the average and then loads the output register.
// The back end takes the next summary only after the last one has gone into
// the output register. The queue holds two finished sets, so the input stalls
// only when sets close faster than the back end finishes them for long enough
// to fill it, or when a stalled output backs it up.
// Threshold registers may be written at any idle time and take effect on the
// next reading.
`include "assert_macros.svh"

module temperature_band_statistics_core #(
    parameter int MAX_READINGS = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [15:0]          reading,
    input  logic                        last_reading,
    input  logic                        cfg_we,
    input  tbs_pkg::cfg_index_t         cfg_index,
    input  logic [tbs_pkg::LEVEL_W-1:0] cfg_wdata,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tbs_pkg::LEVEL_W-1:0] min_valid,
    output logic [tbs_pkg::LEVEL_W-1:0] max_valid,
    output logic [tbs_pkg::LEVEL_W-1:0] average_valid,
    output logic [tbs_pkg::CNT_W-1:0]   valid_total,
    output logic [tbs_pkg::CNT_W-1:0]   skipped_total,
    output logic [tbs_pkg::CNT_W-1:0]   normal_total,
    output logic [tbs_pkg::CNT_W-1:0]   warning_total,
    output logic [tbs_pkg::CNT_W-1:0]   critical_total,
    output logic [tbs_pkg::CNT_W-1:0]   shutdown_total,
    output logic                        critical_seen,
    output logic [tbs_pkg::IDX_W-1:0]   first_critical_index
);
    import tbs_pkg::*;

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    summary_t q_wdata;
    summary_t q_rdata;

    // Front end: classification and running totals.
    tbs_front #(
        .MAX_READINGS (MAX_READINGS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .reading      (reading),
        .last_reading (last_reading),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_full       (q_full),
        .push         (q_push),
        .push_data    (q_wdata)
    );

    // Queue of closed sets.
    tbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: average divider and output register.
    tbs_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .q_empty              (q_empty),
        .pop                  (q_pop),
        .q_data               (q_rdata),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .min_valid            (min_valid),
        .max_valid            (max_valid),
        .average_valid        (average_valid),
        .valid_total          (valid_total),
        .skipped_total        (skipped_total),
        .normal_total         (normal_total),
        .warning_total        (warning_total),
        .critical_total       (critical_total),
        .shutdown_total       (shutdown_total),
        .critical_seen        (critical_seen),
        .first_critical_index (first_critical_index)
    );

endmodule
